// ===== sv/cbor_bounded_item_writer_defines.svh =====
// assertion macros for the bounded cbor item writer
// used by the rtl files under sv; needs nothing else
`ifndef CBOR_BOUNDED_ITEM_WRITER_DEFINES_SVH
`define CBOR_BOUNDED_ITEM_WRITER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CBW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define CBW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cbw_pkg.sv =====
// shared widths, request codes and the head struct of the cbor item writer
// no dependencies
`default_nettype none

package cbw_pkg;

  localparam int OffsetBits   = 16;
  localparam int CapBits      = 16;
  localparam int ValueBits    = 64;
  localparam int HeadMaxBytes = 9;
  localparam int CntBits      = $clog2(HeadMaxBytes + 1);

  localparam logic [OffsetBits-1:0] OffsetMax = {OffsetBits{1'b1}};

  // request codes
  localparam logic [1:0] ReqStart   = 2'd0;
  localparam logic [1:0] ReqHead    = 2'd1;
  localparam logic [1:0] ReqReserve = 2'd2;
  localparam logic [1:0] ReqPayload = 2'd3;

  // additional-info codes of a head byte
  localparam logic [4:0] AiDirectMax = 5'd23;
  localparam logic [4:0] AiOneByte   = 5'd24;
  localparam logic [4:0] AiTwoByte   = 5'd25;
  localparam logic [4:0] AiFourByte  = 5'd26;
  localparam logic [4:0] AiEightByte = 5'd27;

  // encoded head: byte 0 goes out first
  typedef struct packed {
    logic [HeadMaxBytes-1:0][7:0] bytes;
    logic [CntBits-1:0]           count;
  } head_t;

endpackage

`default_nettype wire

// ===== sv/cbw_ifs.sv =====
// valid/ready channel interfaces: request, result and capacity write
// depends on cbw_pkg
`default_nettype none

interface cbw_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [2:0]                    major_type;
  logic [cbw_pkg::ValueBits-1:0] value;
  logic [7:0]                    data_byte;

  modport source (output valid, req_type, major_type, value, data_byte, input ready);
  modport sink   (input valid, req_type, major_type, value, data_byte, output ready);
endinterface

interface cbw_res_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     out_byte;
  logic [cbw_pkg::OffsetBits-1:0] out_addr;
  logic                           byte_valid;
  logic [cbw_pkg::OffsetBits-1:0] offset_now;
  logic                           status;
  logic                           last;

  modport source (output valid, out_byte, out_addr, byte_valid, offset_now, status, last,
                  input ready);
  modport sink   (input valid, out_byte, out_addr, byte_valid, offset_now, status, last,
                  output ready);
endinterface

interface cbw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbw_pkg::CapBits-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== sv/cbw_head_enc.sv =====
// cbor head encoder: major type and argument to 1, 2, 3, 5 or 9 big-endian bytes
// depends on cbw_pkg
`default_nettype none

module cbw_head_enc (
  input  wire logic [2:0]                    major_type,
  input  wire logic [cbw_pkg::ValueBits-1:0] value,
  output cbw_pkg::head_t                     head
);

  always_comb begin
    head = '0;
    // pick the shortest argument form
    if (value <= 64'(cbw_pkg::AiDirectMax)) begin
      head.bytes[0] = {major_type, value[4:0]};
      head.count    = cbw_pkg::CntBits'(1);
    end else if (value <= 64'hFF) begin
      head.bytes[0] = {major_type, cbw_pkg::AiOneByte};
      head.bytes[1] = value[7:0];
      head.count    = cbw_pkg::CntBits'(2);
    end else if (value <= 64'hFFFF) begin
      head.bytes[0] = {major_type, cbw_pkg::AiTwoByte};
      head.bytes[1] = value[15:8];
      head.bytes[2] = value[7:0];
      head.count    = cbw_pkg::CntBits'(3);
    end else if (value <= 64'hFFFF_FFFF) begin
      head.bytes[0] = {major_type, cbw_pkg::AiFourByte};
      head.bytes[1] = value[31:24];
      head.bytes[2] = value[23:16];
      head.bytes[3] = value[15:8];
      head.bytes[4] = value[7:0];
      head.count    = cbw_pkg::CntBits'(5);
    end else begin
      head.bytes[0] = {major_type, cbw_pkg::AiEightByte};
      head.bytes[1] = value[63:56];
      head.bytes[2] = value[55:48];
      head.bytes[3] = value[47:40];
      head.bytes[4] = value[39:32];
      head.bytes[5] = value[31:24];
      head.bytes[6] = value[23:16];
      head.bytes[7] = value[15:8];
      head.bytes[8] = value[7:0];
      head.count    = cbw_pkg::CntBits'(9);
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbor_bounded_item_writer.sv =====
// Bounded CBOR item writer. Start, reserve and payload requests each give one result and
// can be accepted every cycle when res.ready holds. A head request gives one result per
// encoded byte (1, 2, 3, 5 or 9) when it fits a nonzero capacity without error, otherwise
// a single result; its bytes leave a group register one per cycle when res.ready holds,
// and the next request is taken in the cycle its last byte moves to the output register.
// The output register lets one request be accepted while a result still waits. Offset,
// fill pointer and error update in the cycle a request is accepted. Capacity zero counts
// size only. Capacity port: always ready; user must write it only while idle, unenforced.
// depends on cbw_pkg, cbw_ifs, cbw_head_enc and the assertion macro header
`default_nettype none
`include "cbor_bounded_item_writer_defines.svh"

module cbor_bounded_item_writer (
  input wire logic clk,
  input wire logic rst,
  cbw_cfg_if.sink  cfg,
  cbw_req_if.sink  req,
  cbw_res_if.source res
);

  localparam int OB = cbw_pkg::OffsetBits;
  localparam int CB = cbw_pkg::CntBits;

  // architectural state
  logic [cbw_pkg::CapBits-1:0] capacity;
  logic [OB-1:0]               write_offset, write_offset_next;
  logic [OB-1:0]               fill_pointer, fill_pointer_next;
  logic                        error_flag, error_flag_next;

  // group register: results of one request waiting to drain
  logic                                     a_valid;
  logic [cbw_pkg::HeadMaxBytes-1:0][7:0]    a_bytes, a_bytes_next;
  logic [CB-1:0]                            a_cnt, a_cnt_next;
  logic [OB-1:0]                            a_addr, a_addr_next;
  logic                                     a_bvalid, a_bvalid_next;
  logic [OB-1:0]                            a_offset;
  logic                                     a_status;

  // output register
  logic          o_valid;
  logic [7:0]    o_byte;
  logic [OB-1:0] o_addr;
  logic          o_bvalid;
  logic [OB-1:0] o_offset;
  logic          o_status;
  logic          o_last;

  cbw_pkg::head_t head;
  logic           accept, move;

  cbw_head_enc u_head_enc (
    .major_type (req.major_type),
    .value      (req.value),
    .head       (head)
  );

  // handshakes
  assign move      = a_valid && (!o_valid || res.ready);
  assign req.ready = !a_valid || (move && a_cnt == CB'(1));
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  // claim check shared by head and reserve
  logic [cbw_pkg::ValueBits-1:0] claim_len;
  logic [OB-1:0]                 room;
  logic [OB:0]                   claim_sum;
  logic                          len_gt_room, cap_fail, count_mode;

  always_comb begin
    claim_len   = (req.req_type == cbw_pkg::ReqHead) ?
                  cbw_pkg::ValueBits'(head.count) : req.value;
    room        = cbw_pkg::OffsetMax - write_offset;
    len_gt_room = claim_len > cbw_pkg::ValueBits'(room);
    claim_sum   = {1'b0, write_offset} + {1'b0, claim_len[OB-1:0]};
    cap_fail    = len_gt_room || (claim_sum > (OB+1)'(capacity));
    count_mode  = capacity == '0;
  end

  // request decode: state update and result group
  always_comb begin
    write_offset_next = write_offset;
    fill_pointer_next = fill_pointer;
    error_flag_next   = error_flag;
    a_bytes_next      = '0;
    a_cnt_next        = CB'(1);
    a_addr_next       = '0;
    a_bvalid_next     = 1'b0;
    case (req.req_type)
      cbw_pkg::ReqStart: begin
        write_offset_next = '0;
        fill_pointer_next = '0;
        error_flag_next   = 1'b0;
      end
      cbw_pkg::ReqHead, cbw_pkg::ReqReserve: begin
        if (!error_flag) begin
          if (count_mode) begin
            if (len_gt_room) begin
              write_offset_next = cbw_pkg::OffsetMax;
              error_flag_next   = 1'b1;
            end else begin
              write_offset_next = claim_sum[OB-1:0];
            end
          end else if (cap_fail) begin
            error_flag_next = 1'b1;
          end else begin
            write_offset_next = claim_sum[OB-1:0];
          end
          // head bytes go out only when written to a real buffer
          if (req.req_type == cbw_pkg::ReqHead) begin
            if (!count_mode && !cap_fail) begin
              a_bytes_next  = head.bytes;
              a_cnt_next    = head.count;
              a_addr_next   = write_offset;
              a_bvalid_next = 1'b1;
            end
          end else if (count_mode ? !len_gt_room : !cap_fail) begin
            fill_pointer_next = write_offset;
          end
        end
      end
      cbw_pkg::ReqPayload: begin
        if (!error_flag && !count_mode && fill_pointer < write_offset &&
            fill_pointer < capacity) begin
          fill_pointer_next = fill_pointer + OB'(1);
          a_bytes_next[0]   = req.data_byte;
          a_addr_next       = fill_pointer;
          a_bvalid_next     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_offset <= '0;
      fill_pointer <= '0;
      error_flag   <= 1'b0;
    end else if (accept) begin
      write_offset <= write_offset_next;
      fill_pointer <= fill_pointer_next;
      error_flag   <= error_flag_next;
    end
  end

  // group register: load on accept, shift one byte out per move
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (move && a_cnt == CB'(1)) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_bytes  <= a_bytes_next;
      a_cnt    <= a_cnt_next;
      a_addr   <= a_addr_next;
      a_bvalid <= a_bvalid_next;
      a_offset <= write_offset_next;
      a_status <= error_flag_next;
    end else if (move) begin
      a_bytes <= a_bytes >> 8;
      a_cnt   <= a_cnt - CB'(1);
      a_addr  <= a_addr + OB'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (move) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      o_byte   <= a_bytes[0];
      o_addr   <= a_addr;
      o_bvalid <= a_bvalid;
      o_offset <= a_offset;
      o_status <= a_status;
      o_last   <= a_cnt == CB'(1);
    end
  end

  assign res.valid      = o_valid;
  assign res.out_byte   = o_byte;
  assign res.out_addr   = o_addr;
  assign res.byte_valid = o_bvalid;
  assign res.offset_now = o_offset;
  assign res.status     = o_status;
  assign res.last       = o_last;

  // checks
  `CBW_ASSERT_IMPL(a_cnt_live, clk, rst, a_valid, a_cnt != '0, "empty result group held")
  `CBW_ASSERT_IMPL(nobyte_is_last, clk, rst, res.valid && !res.byte_valid, res.last,
                   "result without a byte is not the last of its request")
  `CBW_ASSERT_IMPL(byte_no_error, clk, rst, res.valid && res.byte_valid, !res.status,
                   "byte emitted with error flag set")
  `CBW_ASSERT_IMPL(accept_frees_group, clk, rst, accept && a_valid,
                   move && a_cnt == CB'(1), "request accepted over an undrained group")
  `CBW_ASSERT_NEXT(head_addr_step, clk, rst, res.valid && res.ready && !res.last,
                   res.valid && res.out_addr == OB'($past(res.out_addr) + OB'(1)),
                   "head bytes not at consecutive addresses")

endmodule

`default_nettype wire
